// ===== rtl/core/ts_pes_payload_reassembler_core_macros.svh =====
// Assertion macros for the transport stream payload reassembler.
// They expect signals named clk and arst_n in the scope where they are used.
`ifndef TS_PES_PAYLOAD_REASSEMBLER_CORE_MACROS_SVH
`define TS_PES_PAYLOAD_REASSEMBLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSPR_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSPR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tspr_pkg.sv =====
// Shared types and constants of the transport stream payload reassembler.
// Used by the channel interfaces, the result buffer and the top level.
`default_nettype none

package tspr_pkg;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_ABANDON  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic        unit_first;
	} result_t;

	localparam int unsigned PID_W = 13;
	localparam int unsigned CC_W = 4;

	localparam logic [7:0] POS_PID_HIGH = 8'd1;
	localparam logic [7:0] POS_PID_LOW = 8'd2;
	localparam logic [7:0] POS_CONTROL = 8'd3;
	localparam logic [7:0] POS_ADAPT_LEN = 8'd4;
	localparam logic [7:0] POS_LAST = 8'd255;

	localparam logic [8:0] OFFSET_PLAIN = 9'd4;
	localparam logic [8:0] OFFSET_ADAPT = 9'd5;

endpackage

`default_nettype wire

// ===== rtl/core/tspr_channels.sv =====
// Valid/ready channel interfaces for the transport stream payload reassembler.
// Depends on tspr_pkg for the result kind type.
`default_nettype none

interface tspr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       packet_start;

	modport source (output valid, output data_byte, output packet_start, input ready);
	modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface tspr_out_if;
	logic                valid;
	logic                ready;
	tspr_pkg::kind_t     kind;
	logic [7:0]          payload_byte;
	logic                unit_first;

	modport source (output valid, output kind, output payload_byte, output unit_first,
		input ready);
	modport sink (input valid, input kind, input payload_byte, input unit_first,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tspr_out_fifo.sv =====
// Two-entry result buffer that decouples the parser from the output handshake.
// Depends on tspr_pkg for the result item type.
`default_nettype none

module tspr_out_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tspr_pkg::result_t push_data,
	output logic                   room,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output tspr_pkg::result_t      pop_data
);

	tspr_pkg::result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign room = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ts_pes_payload_reassembler_core.sv =====
// Path: an accepted byte is held in the input register, and its result is written into the result buffer.
// Throughput: one byte per cycle while the result buffer has room; the input register, the header and
// payload logic and the two-entry result buffer all run at one item per clock unless the output stalls.
// Reset: all parser state clears, the payload offset returns to four and the
// watched packet id returns to zero; the result buffer empties.
// Depends on tspr_pkg, tspr_channels, tspr_out_fifo and the assertion macro header.
`default_nettype none

`include "ts_pes_payload_reassembler_core_macros.svh"

module ts_pes_payload_reassembler_core #(
	parameter int unsigned PACKET_BYTES = 188
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tspr_pkg::PID_W-1:0]  cfg_data,
	tspr_in_if.sink                          stream,
	tspr_out_if.source                       result
);

	localparam logic [7:0] PKT_LEN8 = 8'(PACKET_BYTES);
	localparam logic [8:0] PKT_LEN9 = 9'(PACKET_BYTES);

	logic [tspr_pkg::PID_W-1:0] watch_pid_q;

	logic       s1_valid_q;
	logic [7:0] data_s1;
	logic       start_s1;

	logic [7:0]                pos_q, pos_n;
	logic                      app_q, app_n;
	logic [4:0]                pid_hi_q, pid_hi_n;
	logic                      match_q, match_n;
	logic                      start_seen_q, start_seen_n;
	logic [1:0]                afc_q, afc_n;
	logic [8:0]                off_q, off_n;
	logic [tspr_pkg::CC_W-1:0] cc_q, cc_n;
	logic                      cc_valid_q, cc_valid_n;
	logic                      first_q, first_n;

	logic                      res_v;
	tspr_pkg::result_t         res;
	logic                      room;
	logic                      adv;
	tspr_pkg::result_t         pop_data;

	logic [1:0]                afc_in;
	logic [tspr_pkg::CC_W-1:0] cc_in;
	logic [tspr_pkg::CC_W-1:0] cc_expect;
	logic [8:0]                adapt_off;

	assign adv = s1_valid_q && room;
	assign stream.ready = !s1_valid_q || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_pid_q <= '0;
		end else if (cfg_we) begin
			watch_pid_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (stream.ready) begin
			s1_valid_q <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_s1 <= stream.data_byte;
			start_s1 <= stream.packet_start;
		end
	end

	assign afc_in = data_s1[5:4];
	assign cc_in = data_s1[3:0];
	assign cc_expect = afc_in[0] ? (cc_q + 4'd1) : cc_q;
	assign adapt_off = 9'(data_s1) + tspr_pkg::OFFSET_ADAPT;

	always_comb begin
		pos_n = pos_q;
		app_n = app_q;
		pid_hi_n = pid_hi_q;
		match_n = match_q;
		start_seen_n = start_seen_q;
		afc_n = afc_q;
		off_n = off_q;
		cc_n = cc_q;
		cc_valid_n = cc_valid_q;
		first_n = first_q;
		res_v = 1'b0;
		res.kind = tspr_pkg::KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.unit_first = 1'b0;

		if (start_s1) begin
			pos_n = 8'd0;
			match_n = 1'b0;
			start_seen_n = 1'b0;
			afc_n = 2'd0;
			off_n = tspr_pkg::OFFSET_PLAIN;
		end else if (pos_q != tspr_pkg::POS_LAST) begin
			pos_n = pos_q + 8'd1;
		end

		if (pos_n < PKT_LEN8) begin
			if (pos_n == tspr_pkg::POS_PID_HIGH) begin
				start_seen_n = data_s1[6];
				pid_hi_n = data_s1[4:0];
				match_n = 1'b0;
			end else if (pos_n == tspr_pkg::POS_PID_LOW) begin
				match_n = ({pid_hi_q, data_s1} == watch_pid_q);
			end else if (pos_n == tspr_pkg::POS_CONTROL) begin
				if (match_n) begin
					afc_n = afc_in;
					if (cc_valid_q && (cc_in != cc_expect) && app_q) begin
						app_n = 1'b0;
						first_n = 1'b0;
						res_v = 1'b1;
						res.kind = tspr_pkg::KIND_ABANDON;
					end
					cc_n = cc_in;
					cc_valid_n = 1'b1;
					if (!afc_in[0] || (!start_seen_n && !app_n)) begin
						match_n = 1'b0;
					end else begin
						if (start_seen_n) begin
							if (app_n && !res_v) begin
								res_v = 1'b1;
								res.kind = tspr_pkg::KIND_COMPLETE;
							end
							app_n = 1'b1;
							first_n = 1'b1;
						end
						off_n = afc_in[1] ? tspr_pkg::OFFSET_ADAPT : tspr_pkg::OFFSET_PLAIN;
					end
				end
			end else if (pos_n == tspr_pkg::POS_ADAPT_LEN && match_n && afc_n[1]) begin
				off_n = (adapt_off > PKT_LEN9) ? PKT_LEN9 : adapt_off;
			end else if (pos_n >= tspr_pkg::POS_ADAPT_LEN && match_n
					&& {1'b0, pos_n} >= off_n) begin
				res_v = 1'b1;
				res.kind = tspr_pkg::KIND_PAYLOAD;
				res.payload_byte = data_s1;
				res.unit_first = first_n;
				first_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
			app_q <= 1'b0;
			pid_hi_q <= 5'd0;
			match_q <= 1'b0;
			start_seen_q <= 1'b0;
			afc_q <= 2'd0;
			off_q <= tspr_pkg::OFFSET_PLAIN;
			cc_q <= '0;
			cc_valid_q <= 1'b0;
			first_q <= 1'b0;
		end else if (adv) begin
			pos_q <= pos_n;
			app_q <= app_n;
			pid_hi_q <= pid_hi_n;
			match_q <= match_n;
			start_seen_q <= start_seen_n;
			afc_q <= afc_n;
			off_q <= off_n;
			cc_q <= cc_n;
			cc_valid_q <= cc_valid_n;
			first_q <= first_n;
		end
	end

	tspr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && res_v),
		.push_data (res),
		.room      (room),
		.pop_valid (result.valid),
		.pop_ready (result.ready),
		.pop_data  (pop_data)
	);

	assign result.kind = pop_data.kind;
	assign result.payload_byte = pop_data.payload_byte;
	assign result.unit_first = pop_data.unit_first;

	`TSPR_ASSERT_SAME(a_close_marks_abandon, adv && app_q && !app_n, res_v && res.kind == tspr_pkg::KIND_ABANDON, "unit closed without an abandon marker")
	`TSPR_ASSERT_SAME(a_first_on_payload, res_v && res.unit_first, res.kind == tspr_pkg::KIND_PAYLOAD, "unit_first set on a marker")
	`TSPR_ASSERT_SAME(a_payload_after_header, res_v && res.kind == tspr_pkg::KIND_PAYLOAD, pos_n >= tspr_pkg::POS_ADAPT_LEN && pos_n < PKT_LEN8, "payload byte emitted from the header")
	`TSPR_ASSERT_NEXT(a_first_clears, adv && res_v && res.kind == tspr_pkg::KIND_PAYLOAD, !first_q, "first flag kept after a payload byte")

endmodule

`default_nettype wire

// ===== sim/ts_pes_payload_reassembler_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the transport stream payload reassembler: it tracks the header parser,
// predicts every result beat from the accepted input beats and compares them in order.
// Depends on tspr_pkg and the channel interfaces in tspr_channels.
module ts_pes_payload_reassembler_checker #(
	parameter int unsigned PACKET_BYTES = 188
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [tspr_pkg::PID_W-1:0]  cfg_data,
	tspr_in_if                               stream,
	tspr_out_if                              result,
	output int                               errors,
	output int                               pending
);

	logic [tspr_pkg::PID_W-1:0] watched_pid;
	logic [7:0]                 position;
	logic                       unit_open;
	logic [4:0]                 pid_high;
	logic                       carry_payload;
	logic                       pusi;
	logic [1:0]                 afc_held;
	logic [8:0]                 first_payload_pos;
	logic [tspr_pkg::CC_W-1:0]  last_cc;
	logic                       cc_known;
	logic                       first_due;

	tspr_pkg::result_t          outgoing_q[$];
	tspr_pkg::result_t          want;
	int                         mismatch_count;

	task automatic queue_result(input tspr_pkg::kind_t k, input logic [7:0] d, input logic f);
		tspr_pkg::result_t r;
		r.kind = k;
		r.payload_byte = d;
		r.unit_first = f;
		outgoing_q.push_back(r);
	endtask

	task automatic parse_beat(input logic [7:0] b, input logic ps);
		logic [1:0]                afc;
		logic [tspr_pkg::CC_W-1:0] cc;
		logic [tspr_pkg::CC_W-1:0] cc_next;
		logic                      gives_payload;
		logic                      marked;
		logic [8:0]                off;
		marked = 1'b0;
		if (ps) begin
			position = 8'd0;
			carry_payload = 1'b0;
			pusi = 1'b0;
			afc_held = 2'd0;
			first_payload_pos = tspr_pkg::OFFSET_PLAIN;
		end else if (position != tspr_pkg::POS_LAST) begin
			position = position + 8'd1;
		end
		if (position >= PACKET_BYTES)
			return;
		if (position == tspr_pkg::POS_PID_HIGH) begin
			pusi = b[6];
			pid_high = b[4:0];
			carry_payload = 1'b0;
		end else if (position == tspr_pkg::POS_PID_LOW) begin
			carry_payload = ({pid_high, b} == watched_pid);
		end else if (position == tspr_pkg::POS_CONTROL) begin
			if (carry_payload) begin
				afc = b[5:4];
				cc = b[3:0];
				gives_payload = afc[0];
				afc_held = afc;
				cc_next = gives_payload ? last_cc + 4'd1 : last_cc;
				if (cc_known && cc != cc_next && unit_open) begin
					unit_open = 1'b0;
					first_due = 1'b0;
					queue_result(tspr_pkg::KIND_ABANDON, 8'd0, 1'b0);
					marked = 1'b1;
				end
				last_cc = cc;
				cc_known = 1'b1;
				if (!gives_payload || (!pusi && !unit_open)) begin
					carry_payload = 1'b0;
				end else begin
					if (pusi) begin
						if (unit_open && !marked)
							queue_result(tspr_pkg::KIND_COMPLETE, 8'd0, 1'b0);
						unit_open = 1'b1;
						first_due = 1'b1;
					end
					first_payload_pos = afc[1] ? tspr_pkg::OFFSET_ADAPT
						: tspr_pkg::OFFSET_PLAIN;
				end
			end
			return;
		end else if (position == tspr_pkg::POS_ADAPT_LEN && carry_payload && afc_held[1]) begin
			off = tspr_pkg::OFFSET_ADAPT + {1'b0, b};
			if (off > PACKET_BYTES)
				off = 9'(PACKET_BYTES);
			first_payload_pos = off;
			return;
		end
		if (position >= tspr_pkg::POS_ADAPT_LEN && carry_payload
				&& {1'b0, position} >= first_payload_pos) begin
			queue_result(tspr_pkg::KIND_PAYLOAD, b, first_due);
			first_due = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_pid = '0;
			position = 8'd0;
			unit_open = 1'b0;
			pid_high = 5'd0;
			carry_payload = 1'b0;
			pusi = 1'b0;
			afc_held = 2'd0;
			first_payload_pos = tspr_pkg::OFFSET_PLAIN;
			last_cc = '0;
			cc_known = 1'b0;
			first_due = 1'b0;
			outgoing_q.delete();
			mismatch_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				watched_pid = cfg_data;
			if (result.valid && result.ready) begin
				if (outgoing_q.size() == 0) begin
					$error("result beat with nothing expected: kind %0d, payload_byte %0d",
						result.kind, result.payload_byte);
					mismatch_count++;
				end else begin
					want = outgoing_q.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, result.kind);
						mismatch_count++;
					end
					if (result.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %0d, actual %0d", want.payload_byte,
							result.payload_byte);
						mismatch_count++;
					end
					if (result.unit_first !== want.unit_first) begin
						$error("unit_first: expected %0d, actual %0d", want.unit_first,
							result.unit_first);
						mismatch_count++;
					end
				end
			end
			if (stream.valid && stream.ready)
				parse_beat(stream.data_byte, stream.packet_start);
			errors <= mismatch_count;
			pending <= outgoing_q.size();
		end
	end

endmodule

// ===== sim/ts_pes_payload_reassembler_core_test.sv =====
`timescale 1ns / 1ps
// Top of the reassembler testbench: clock, reset, packet stimulus, result back-pressure,
// watched packet id changes and the verdict. Depends on tspr_pkg, tspr_channels,
// the reassembler core and ts_pes_payload_reassembler_checker.
module ts_pes_payload_reassembler_core_test;

	localparam int unsigned PACKET_BYTES = 188;
	localparam int unsigned ITEM_TARGET = 1600;
	localparam int unsigned PHASES = 5;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_CYCLES = 8;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [tspr_pkg::PID_W-1:0] cfg_data;

	tspr_in_if  stream ();
	tspr_out_if result ();

	int                         errors;
	int                         pending;
	int                         beats_sent;
	int                         quiet_cycles;
	bit                         idling_on;
	bit                         long_hold_req;
	logic [tspr_pkg::CC_W-1:0]  cont_count;
	logic [tspr_pkg::PID_W-1:0] phase_pid;

	ts_pes_payload_reassembler_core #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.stream(stream),
		.result(result)
	);

	ts_pes_payload_reassembler_checker #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.stream(stream),
		.result(result),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream.valid && stream.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			result.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic ps);
		if (idling_on && $urandom_range(0, 15) == 0) begin
			stream.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		stream.valid <= 1'b1;
		stream.data_byte <= b;
		stream.packet_start <= ps;
		@(posedge clk);
		while (!stream.ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_packet(input logic [tspr_pkg::PID_W-1:0] pid, input logic start,
			input logic [1:0] afc, input logic [tspr_pkg::CC_W-1:0] cc,
			input logic [7:0] adapt_len, input int length);
		logic [7:0] b;
		logic [7:0] r;
		for (int i = 0; i < length; i++) begin
			r = 8'($urandom);
			case (i)
				0: b = ($urandom_range(0, 3) == 0) ? r : 8'h47;
				1: b = {r[7], start, r[5], pid[12:8]};
				2: b = pid[7:0];
				3: b = {r[7:6], afc, cc};
				4: b = afc[1] ? adapt_len : r;
				default: b = r;
			endcase
			send_beat(b, i == 0);
		end
	endtask

	task automatic send_random_packet(input logic [tspr_pkg::PID_W-1:0] watch);
		logic [tspr_pkg::PID_W-1:0] pid;
		logic                       start;
		logic [1:0]                 afc;
		logic [tspr_pkg::CC_W-1:0]  cc;
		logic [7:0]                 adapt_len;
		int                         length;
		int                         pick;
		pick = $urandom_range(0, 7);
		if (pick < 6)
			pid = watch;
		else if (pick == 6)
			pid = watch ^ (13'd1 << $urandom_range(0, 12));
		else
			pid = 13'($urandom_range(0, 8191));
		start = ($urandom_range(0, 2) == 0);
		pick = $urandom_range(0, 9);
		afc = (pick < 6) ? 2'd1 : (pick < 8) ? 2'd3 : (pick == 8) ? 2'd2 : 2'd0;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			length = PACKET_BYTES;
		else if (pick == 2)
			length = $urandom_range(1, 3);
		else if (pick == 3)
			length = $urandom_range(PACKET_BYTES + 1, 270);
		else
			length = $urandom_range(5, 24);
		if (pid == watch) begin
			cc = afc[0] ? cont_count + 4'd1 : cont_count;
			if ($urandom_range(0, 9) == 0)
				cc = 4'($urandom_range(0, 15));
			if (length > 3)
				cont_count = cc;
		end else begin
			cc = 4'($urandom_range(0, 15));
		end
		adapt_len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(180, 255))
			: 8'($urandom_range(0, 12));
		send_packet(pid, start, afc, cc, adapt_len, length);
	endtask

	task automatic set_watch(input logic [tspr_pkg::PID_W-1:0] pid);
		stream.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= pid;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		stream.valid = 1'b0;
		stream.data_byte = 8'd0;
		stream.packet_start = 1'b0;
		result.ready = 1'b0;
		idling_on = 1'b1;
		long_hold_req = 1'b0;
		beats_sent = 0;
		quiet_cycles = 0;
		cont_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes before any packet start look like the tail of a header on packet id zero.
		send_beat(8'h40, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h10, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);

		set_watch(13'h0000);
		send_packet(13'h0000, 1'b1, 2'd1, 4'd1, 8'd0, 8);
		send_packet(13'h0000, 1'b0, 2'd1, 4'd3, 8'd0, 6);
		send_packet(13'h0000, 1'b0, 2'd1, 4'd4, 8'd0, 6);
		send_packet(13'h0000, 1'b1, 2'd3, 4'd5, 8'd2, 10);
		send_packet(13'h0000, 1'b0, 2'd2, 4'd5, 8'd0, 5);
		send_packet(13'h0000, 1'b0, 2'd0, 4'd5, 8'd0, 5);
		send_packet(13'h0000, 1'b1, 2'd3, 4'd6, 8'd200, PACKET_BYTES);
		send_packet(13'h0000, 1'b0, 2'd1, 4'd6, 8'd0, 6);
		send_packet(13'h0000, 1'b1, 2'd1, 4'd7, 8'd0, 3);
		send_packet(13'h0000, 1'b1, 2'd1, 4'd8, 8'd0, 300);
		send_packet(13'h0000, 1'b1, 2'd3, 4'd9, 8'd183, PACKET_BYTES);

		set_watch(13'h1FFF);
		send_packet(13'h1FFF, 1'b1, 2'd1, 4'd15, 8'd0, 8);
		send_packet(13'h1FFF, 1'b0, 2'd1, 4'd0, 8'd0, 8);
		send_packet(13'h1FFE, 1'b1, 2'd1, 4'd1, 8'd0, 6);
		cont_count = 4'd0;

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: phase_pid = 13'h1FFF;
				2: phase_pid = 13'h0000;
				default: phase_pid = 13'($urandom_range(0, 8191));
			endcase
			set_watch(phase_pid);
			idling_on = (phase < PHASES - 1);
			if (phase == 1) begin
				long_hold_req = 1'b1;
				cont_count = cont_count + 4'd1;
				send_packet(phase_pid, 1'b1, 2'd1, cont_count, 8'd0, PACKET_BYTES);
			end
			while (beats_sent < (phase + 1) * ITEM_TARGET / PHASES)
				send_random_packet(phase_pid);
		end

		stream.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
